@@ sv/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define CHK_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define CHK_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/mbps_pkg.sv @@
package mbps_pkg;

    localparam int PATTERN_BYTES_DEF = 16;
    localparam int OFFSET_BITS_DEF   = 32;
    localparam int PAT_MAX_BYTES     = 16;
    localparam int OUT_OFFSET_W      = 32;
    localparam int CFG_INDEX_W       = 8;
    localparam int CFG_DATA_W        = 64;
    localparam int CARE_W            = 16;
    localparam int LEN_REG_W         = 5;
    localparam int QUEUE_DEPTH       = 4;

    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH   = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CARE_MASK      = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 8'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_scan_in;

    typedef struct packed {
        logic                    found;
        logic [OUT_OFFSET_W-1:0] match_offset;
    } t_scan_out;

    // one classified byte passed from front to back
    typedef struct packed {
        logic                    hit;
        logic                    last;
        logic [OUT_OFFSET_W-1:0] offset;
    } t_scan_ev;

    typedef struct packed {
        logic     valid;
        t_scan_ev ev;
    } t_q_head;

endpackage

@@ sv/mbps_queue.sv @@
`include "assert_macros.svh"

module mbps_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  mbps_pkg::t_scan_ev i_ev,
    output logic               o_full,
    input  logic               i_pop,
    output mbps_pkg::t_q_head  o_head
);
    import mbps_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_scan_ev         r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign o_full       = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.ev    = r_mem[r_rd];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_ev;
        end
    end

    `CHK_ALWAYS(a_cnt_max, i_clk, i_rst_n, r_count <= CNT_W'(QUEUE_DEPTH), "queue count above depth")
    `CHK_IMPL(a_no_pop_empty, i_clk, i_rst_n, i_pop, r_count != '0, "pop from empty queue")

endmodule

@@ sv/mbps_front.sv @@
`include "assert_macros.svh"

module mbps_front #(
    parameter int PATTERN_BYTES = mbps_pkg::PATTERN_BYTES_DEF,
    parameter int OFFSET_BITS   = mbps_pkg::OFFSET_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [mbps_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_valid,
    input  mbps_pkg::t_scan_in               i_data,
    output logic                             o_ready,
    output logic                             o_push,
    output mbps_pkg::t_scan_ev               o_ev,
    input  logic                             i_q_full
);
    import mbps_pkg::*;

    localparam int LEN_W = $clog2(PATTERN_BYTES + 1);
    localparam int IDX_W = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;
    localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;
    localparam logic [LEN_W-1:0]       LEN_MAX = LEN_W'(PATTERN_BYTES);

    logic [CFG_DATA_W-1:0]  r_pat_low;
    logic [CFG_DATA_W-1:0]  r_pat_high;
    logic [CARE_W-1:0]      r_care;
    logic [LEN_W-1:0]       r_len;
    logic [LEN_W-1:0]       n_len;
    logic [LEN_REG_W-1:0]   cfg_len;

    logic [7:0]             r_win [PATTERN_BYTES];
    logic [7:0]             n_win [PATTERN_BYTES];
    logic [OFFSET_BITS-1:0] r_pos;
    logic [OFFSET_BITS-1:0] n_pos;
    logic [OFFSET_BITS-1:0] base_pos;
    logic                   r_last;
    logic                   r_s1_valid;

    logic                    accept;
    logic [2*CFG_DATA_W-1:0] pat_all;
    logic [PATTERN_BYTES-1:0] byte_ok;
    logic [OFFSET_BITS-1:0]  diff;

    assign accept  = i_valid && o_ready;
    assign o_ready = !r_s1_valid || !i_q_full;
    assign o_push  = r_s1_valid && !i_q_full;
    assign pat_all = {r_pat_high, r_pat_low};

    // length clamp done once at write time
    assign cfg_len = i_cfg_data[LEN_REG_W-1:0];
    always_comb begin
        if (cfg_len == '0) begin
            n_len = LEN_W'(1);
        end else if (int'(cfg_len) > PATTERN_BYTES) begin
            n_len = LEN_MAX;
        end else begin
            n_len = LEN_W'(cfg_len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_care     <= '0;
            r_len      <= LEN_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PATTERN_LOW: begin
                    r_pat_low <= i_cfg_data;
                end
                CFG_PATTERN_HIGH: begin
                    r_pat_high <= i_cfg_data;
                end
                CFG_CARE_MASK: begin
                    r_care <= i_cfg_data[CARE_W-1:0];
                end
                CFG_PATTERN_LENGTH: begin
                    r_len <= n_len;
                end
                default: begin
                end
            endcase
        end
    end

    // window shift, cleared after a region's last byte
    always_comb begin
        n_win[0] = i_data.data_byte;
        for (int k = 1; k < PATTERN_BYTES; k++) begin
            n_win[k] = r_last ? 8'h00 : r_win[k-1];
        end
        base_pos = r_last ? '0 : r_pos;
        n_pos    = (base_pos == POS_MAX) ? base_pos : base_pos + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last     <= 1'b1;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_last     <= i_data.last_byte;
                r_s1_valid <= 1'b1;
            end else if (o_push) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win <= n_win;
            r_pos <= n_pos;
        end
    end

    for (genvar k = 0; k < PATTERN_BYTES; k++) begin : g_cmp
        if (k < PAT_MAX_BYTES) begin : g_care
            logic [IDX_W-1:0] sel;
            assign sel = IDX_W'(r_len - LEN_W'(k + 1));
            assign byte_ok[k] = (LEN_W'(k) >= r_len) || !r_care[k]
                             || (pat_all[8*k +: 8] == r_win[sel]);
        end else begin : g_wild
            assign byte_ok[k] = 1'b1;
        end
    end

    assign diff        = r_pos - OFFSET_BITS'(r_len);
    assign o_ev.hit    = (&byte_ok) && (r_pos >= OFFSET_BITS'(r_len));
    assign o_ev.last   = r_last;
    assign o_ev.offset = OUT_OFFSET_W'(diff);

    `CHK_NEXT(a_pos_nonzero, i_clk, i_rst_n, accept, r_pos != '0, "position zero after a beat")
    `CHK_NEXT(a_s1_hold, i_clk, i_rst_n, r_s1_valid && i_q_full, r_s1_valid, "stage dropped while queue full")

endmodule

@@ sv/mbps_back.sv @@
`include "assert_macros.svh"

module mbps_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mbps_pkg::t_q_head   i_head,
    output logic                o_pop,
    output logic                o_valid,
    output mbps_pkg::t_scan_out o_data,
    input  logic                i_ready
);
    import mbps_pkg::*;

    logic      r_seen;
    logic      r_out_valid;
    t_scan_out r_out;
    t_scan_out n_out;
    logic      found;
    logic      needs;
    logic      slot_free;
    logic      load;

    assign found     = i_head.ev.hit && !r_seen;
    assign needs     = found || (i_head.ev.last && !r_seen);
    assign slot_free = !r_out_valid || i_ready;
    assign o_pop     = i_head.valid && (!needs || slot_free);
    assign load      = o_pop && needs;

    assign n_out.found        = found;
    assign n_out.match_offset = found ? i_head.ev.offset : '0;

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_seen <= i_head.ev.last ? 1'b0 : (r_seen || i_head.ev.hit);
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    `CHK_NEXT(a_seen_after_hit, i_clk, i_rst_n, o_pop && found && !i_head.ev.last, r_seen, "match not remembered")
    `CHK_IMPL(a_miss_zero, i_clk, i_rst_n, r_out_valid && !r_out.found, r_out.match_offset == '0, "miss with offset")

endmodule

@@ sv/masked_byte_pattern_scan.sv @@
// Wildcard byte signature scanner. Takes one region byte per beat and reports, once per
// region, the offset of the first window of pattern_length bytes that matches the pattern
// (bytes with a clear care bit match anything); a region with no match gets one not-found
// beat on its last byte. Sustained rate is one byte per clock while the queue has room:
// the window compare is one registered stage of parallel byte comparators, then a
// four-entry queue, then the result register. Either side may stall without stopping
// the other until the queue fills. Registers are written through the config port, which
// is always ready; write them only while no bytes are in flight.

`include "assert_macros.svh"

module masked_byte_pattern_scan #(
    parameter int PATTERN_BYTES = mbps_pkg::PATTERN_BYTES_DEF,
    parameter int OFFSET_BITS   = mbps_pkg::OFFSET_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mbps_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  mbps_pkg::t_scan_in               i_data,
    output logic                             o_valid,
    input  logic                             i_ready,
    output mbps_pkg::t_scan_out              o_data
);
    import mbps_pkg::*;

    logic     push;
    logic     q_full;
    logic     pop;
    t_scan_ev ev;
    t_q_head  head;

    assign o_cfg_ready = 1'b1;

    mbps_front #(
        .PATTERN_BYTES (PATTERN_BYTES),
        .OFFSET_BITS   (OFFSET_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .o_ready     (o_ready),
        .o_push      (push),
        .o_ev        (ev),
        .i_q_full    (q_full)
    );

    mbps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ev    (ev),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_head  (head)
    );

    mbps_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_ready (i_ready)
    );

    `CHK_IMPL(a_push_room, i_clk, i_rst_n, push, !q_full, "push into full queue")
    `CHK_IMPL(a_pop_valid, i_clk, i_rst_n, pop, head.valid, "pop without queued beat")
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid, "result dropped while stalled")

endmodule
